// ----- src/wsb_pkg.sv -----
// Shared types, widths and constants of the wheel speed balancer.
package wsb_pkg;

    // Field widths
    localparam int CNT_W   = 16;   // encoder count field
    localparam int SPEED_W = 7;    // wheel speed
    localparam int AXIS_W  = 10;   // wheel axis in mm
    localparam int MPC_W   = 18;   // mm per count, fixed point
    localparam int TOTAL_W = 32;   // whole-mm total on the result
    localparam int DIST_W  = 48;   // internal distance accumulator
    localparam int BIAS_W  = 20;   // signed balance bias

    // Default parameter values
    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = MPC_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_SPEED    = 2'd0,
        CFG_WHEEL_AXIS   = 2'd1,
        CFG_MM_PER_COUNT = 2'd2
    } cfg_idx_t;

    // Register and state reset values
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED   = 7'd50;
    localparam logic [AXIS_W-1:0]  RST_WHEEL_AXIS  = 10'd150;
    localparam logic [MPC_W-1:0]   RST_MM_PER_CNT  = 18'd33470;
    localparam logic [SPEED_W-1:0] RST_WHEEL_SPEED = 7'd30;

    // A speed counts as near the maximum at 19/20 of it.
    localparam int NEAR_MAX_NUM = 20;
    localparam int NEAR_MAX_DEN = 19;

    // Input stream layout
    localparam int S_TDATA_W = 2 * CNT_W;
    localparam int LC_LSB    = 0;
    localparam int RC_LSB    = CNT_W;

    // Result stream layout
    localparam int M_FIELDS_W = 2 * SPEED_W + 2 * TOTAL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int LD_LSB     = 0;
    localparam int RD_LSB     = SPEED_W;
    localparam int LT_LSB     = 2 * SPEED_W;
    localparam int RT_LSB     = 2 * SPEED_W + TOTAL_W;

endpackage

// ----- src/wheel_speed_balancer_core.sv -----
// Top level of the wheel speed balancer: tick pipeline, state and configuration.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+--------------------------------------------
//  s_        | in        | s_tvalid/s_tready  | tdata: left_count, right_count; tuser: error
//  m_        | out       | m_tvalid/m_tready  | tdata: drives, totals; tuser: skipped
//  cfg_      | in        | cfg_wr_en only     | cfg_addr, cfg_wr_data
//
// One tick is taken per cycle while the result is not stalled; it passes the input register and
// then the result register before m_tvalid rises. The encoder products are formed as the tick
// enters the input register; the rest of the update is combinational up to the result register.
// Reset restores the configuration defaults, the speeds, totals and bias, and empties
// both registers. A stalled result holds its data; a new tick is still taken as long as
// the input register is free or moves on in the same cycle.
module wheel_speed_balancer_core #(
    parameter int COUNT_BITS = wsb_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = wsb_pkg::DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wsb_pkg::S_TDATA_W-1:0]   s_tdata,   // left_count, right_count
    input  logic                            s_tuser,   // count_error
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wsb_pkg::M_TDATA_W-1:0]   m_tdata,   // left_drive, right_drive,
                                                       // left_total_mm, right_total_mm
    output logic                            m_tuser,   // skipped
    input  logic                            cfg_wr_en,
    input  logic [wsb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [wsb_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int SPEED_W = wsb_pkg::SPEED_W;
    localparam int DIST_W  = wsb_pkg::DIST_W;
    localparam int BIAS_W  = wsb_pkg::BIAS_W;
    localparam int MPC_W   = wsb_pkg::MPC_W;
    localparam int AXIS_W  = wsb_pkg::AXIS_W;
    localparam int TOTAL_W = wsb_pkg::TOTAL_W;
    localparam int M_TDATA_W = wsb_pkg::M_TDATA_W;
    localparam int CW  = (COUNT_BITS < wsb_pkg::CNT_W) ? COUNT_BITS : wsb_pkg::CNT_W;
    localparam int PW  = CW + MPC_W;
    localparam int DW  = PW + 1;
    localparam int TW  = ((BIAS_W + FRAC_BITS > DW) ? (BIAS_W + FRAC_BITS) : DW) + 2;
    localparam int SPW = SPEED_W + 3;
    localparam int GW  = SPEED_W + 5;

    localparam logic signed [TW-1:0] FRAC_ONES  = {{(TW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    localparam logic signed [TW-1:0] BIAS_MAX_T = TW'(2**(BIAS_W-1) - 1);
    localparam logic signed [TW-1:0] BIAS_MIN_T = TW'(-(2**(BIAS_W-1)));
    localparam logic signed [SPW-1:0] SPEED_TOP = SPW'(2**SPEED_W - 1);

    // Configuration registers
    logic [SPEED_W-1:0] max_speed_reg;
    logic [AXIS_W-1:0]  wheel_axis_reg;
    logic [MPC_W-1:0]   mm_per_count_reg;

    // Input register
    logic          in_valid_reg;
    logic [PW-1:0] dl_reg, dr_reg, dl_next, dr_next;
    logic          err_reg;

    // Tick state
    logic [SPEED_W-1:0]       left_speed_reg, right_speed_reg;
    logic [SPEED_W-1:0]       left_speed_next, right_speed_next;
    logic [DIST_W-1:0]        left_dist_reg, right_dist_reg;
    logic [DIST_W-1:0]        left_dist_next, right_dist_next;
    logic signed [BIAS_W-1:0] bias_reg, bias_next;

    // Result register
    logic                         out_valid_reg;
    logic [wsb_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                         out_skip_reg;

    logic advance, fire;

    // Datapath intermediates
    logic signed [BIAS_W-1:0] bias_half, bias_first, bias_upd;
    logic signed [DW-1:0]     delta;
    logic [DIST_W:0]          left_sum, right_sum, drift_limit;
    logic signed [DIST_W:0]   drift_r, drift_l;
    logic [GW-1:0]            ls_x20, rs_x20, ms_x19;
    logic signed [SPW-1:0]    ms, ls, rs;
    logic [SPEED_W-1:0]       ls_upd, rs_upd;

    function automatic logic signed [BIAS_W-1:0] bias_add(
        input logic signed [BIAS_W-1:0] b,
        input logic signed [TW-1:0]     x
    );
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] q;
        t = (TW'(b) <<< FRAC_BITS) + x;
        // Round toward zero before the arithmetic shift.
        if (t[TW-1]) begin
            t = t + FRAC_ONES;
        end
        q = t >>> FRAC_BITS;
        if (q > BIAS_MAX_T) begin
            return BIAS_MAX_T[BIAS_W-1:0];
        end else if (q < BIAS_MIN_T) begin
            return BIAS_MIN_T[BIAS_W-1:0];
        end
        return q[BIAS_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] whole_mm(input logic [DIST_W-1:0] d);
        logic [DIST_W-1:0] w;
        w = d >> FRAC_BITS;
        return (|w[DIST_W-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : w[TOTAL_W-1:0];
    endfunction

    function automatic logic [SPEED_W-1:0] speed_clamp(input logic signed [SPW-1:0] s);
        if (s < 0) begin
            return '0;
        end else if (s > SPEED_TOP) begin
            return {SPEED_W{1'b1}};
        end
        return s[SPEED_W-1:0];
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_skip_reg;

    // Distance products are formed on the way into the input register.
    assign dl_next = {{MPC_W{1'b0}}, s_tdata[wsb_pkg::LC_LSB +: CW]}
                   * {{CW{1'b0}}, mm_per_count_reg};
    assign dr_next = {{MPC_W{1'b0}}, s_tdata[wsb_pkg::RC_LSB +: CW]}
                   * {{CW{1'b0}}, mm_per_count_reg};

    // Bias update
    assign bias_half  = (bias_reg + $signed({{(BIAS_W-1){1'b0}}, bias_reg[BIAS_W-1]})) >>> 1;
    assign delta      = $signed({1'b0, dr_reg}) - $signed({1'b0, dl_reg});
    assign bias_first = bias_add(bias_half, -TW'(delta));
    assign bias_upd   = (bias_first > 0) ? bias_add(bias_first, TW'(delta)) : bias_first;

    // Saturating distance totals and drift
    assign left_sum    = {1'b0, left_dist_reg} + (DIST_W+1)'(dl_reg);
    assign right_sum   = {1'b0, right_dist_reg} + (DIST_W+1)'(dr_reg);
    assign drift_limit = (DIST_W+1)'(wheel_axis_reg) << (FRAC_BITS - 2);

    always_comb begin
        logic [DIST_W-1:0] l_tot;
        logic [DIST_W-1:0] r_tot;
        l_tot = left_sum[DIST_W] ? {DIST_W{1'b1}} : left_sum[DIST_W-1:0];
        r_tot = right_sum[DIST_W] ? {DIST_W{1'b1}} : right_sum[DIST_W-1:0];
        drift_r = $signed({1'b0, r_tot}) - $signed({1'b0, l_tot});
        drift_l = $signed({1'b0, l_tot}) - $signed({1'b0, r_tot});
        left_dist_next  = err_reg ? left_dist_reg : l_tot;
        right_dist_next = err_reg ? right_dist_reg : r_tot;
    end

    // Speed update: bias step, creep toward the maximum, drift correction, clamp.
    assign ms_x19 = {{(GW-SPEED_W){1'b0}}, max_speed_reg} * GW'(wsb_pkg::NEAR_MAX_DEN);
    assign ls_x20 = {{(GW-SPEED_W){1'b0}}, left_speed_reg} * GW'(wsb_pkg::NEAR_MAX_NUM);
    assign rs_x20 = {{(GW-SPEED_W){1'b0}}, right_speed_reg} * GW'(wsb_pkg::NEAR_MAX_NUM);
    assign ms     = $signed({3'b000, max_speed_reg});

    always_comb begin
        ls = $signed({3'b000, left_speed_reg});
        rs = $signed({3'b000, right_speed_reg});
        if (bias_first < 0) begin
            if (ls_x20 < ms_x19) begin
                ls = ls + SPW'(1);
            end else begin
                rs = rs - SPW'(2);
            end
        end else if (bias_first > 0) begin
            if (rs_x20 < ms_x19) begin
                rs = rs + SPW'(1);
            end else begin
                ls = ls - SPW'(2);
            end
        end
        if (ls < ms) begin
            ls = ls + SPW'(1);
        end
        if (rs < ms) begin
            rs = rs + SPW'(1);
        end
        if (drift_r > $signed(drift_limit)) begin
            if (ls < ms) begin
                ls = ls + SPW'(1);
            end else begin
                rs = rs - SPW'(1);
            end
        end
        if (drift_l > $signed(drift_limit)) begin
            if (rs < ms) begin
                rs = rs + SPW'(1);
            end else begin
                ls = ls - SPW'(1);
            end
        end
        ls_upd = speed_clamp(ls);
        rs_upd = speed_clamp(rs);
    end

    assign left_speed_next  = err_reg ? left_speed_reg : ls_upd;
    assign right_speed_next = err_reg ? right_speed_reg : rs_upd;
    assign bias_next        = err_reg ? bias_reg : bias_upd;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg    <= wsb_pkg::RST_MAX_SPEED;
            wheel_axis_reg   <= wsb_pkg::RST_WHEEL_AXIS;
            mm_per_count_reg <= wsb_pkg::RST_MM_PER_CNT;
        end else if (cfg_wr_en) begin
            case (wsb_pkg::cfg_idx_t'(cfg_addr))
                wsb_pkg::CFG_MAX_SPEED: begin
                    max_speed_reg <= cfg_wr_data[SPEED_W-1:0];
                end
                wsb_pkg::CFG_WHEEL_AXIS: begin
                    wheel_axis_reg <= cfg_wr_data[AXIS_W-1:0];
                end
                wsb_pkg::CFG_MM_PER_COUNT: begin
                    mm_per_count_reg <= cfg_wr_data[MPC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            dl_reg  <= dl_next;
            dr_reg  <= dr_next;
            err_reg <= s_tuser;
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_speed_reg  <= wsb_pkg::RST_WHEEL_SPEED;
            right_speed_reg <= wsb_pkg::RST_WHEEL_SPEED;
            left_dist_reg   <= '0;
            right_dist_reg  <= '0;
            bias_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                left_speed_reg  <= left_speed_next;
                right_speed_reg <= right_speed_next;
                left_dist_reg   <= left_dist_next;
                right_dist_reg  <= right_dist_next;
                bias_reg        <= bias_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= M_TDATA_W'({whole_mm(right_dist_next),
                                        whole_mm(left_dist_next),
                                        right_speed_next,
                                        left_speed_next});
            out_skip_reg <= err_reg;
        end
    end

endmodule

// ----- src/wsb_checker.sv -----
// Port-level checks on the result stream of the wheel speed balancer, bound to the top level.
module wsb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wsb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    localparam int SPEED_W = wsb_pkg::SPEED_W;
    localparam int TOTAL_W = wsb_pkg::TOTAL_W;

    logic                          have_last_reg;
    logic [wsb_pkg::M_TDATA_W-1:0] last_data_reg;

    // Remember the last transferred result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_last_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            have_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            last_data_reg <= m_tdata;
        end
    end

    // A skipped tick repeats the speeds and totals of the result before it.
    a_skip_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && have_last_reg |->
            m_tdata[wsb_pkg::LD_LSB +: SPEED_W] == last_data_reg[wsb_pkg::LD_LSB +: SPEED_W]
         && m_tdata[wsb_pkg::RD_LSB +: SPEED_W] == last_data_reg[wsb_pkg::RD_LSB +: SPEED_W]
         && m_tdata[wsb_pkg::LT_LSB +: TOTAL_W] == last_data_reg[wsb_pkg::LT_LSB +: TOTAL_W]
         && m_tdata[wsb_pkg::RT_LSB +: TOTAL_W] == last_data_reg[wsb_pkg::RT_LSB +: TOTAL_W])
        else $error("skipped tick changed the state");

    // Totals never decrease from one result to the next.
    a_totals_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && have_last_reg |->
            m_tdata[wsb_pkg::LT_LSB +: TOTAL_W] >= last_data_reg[wsb_pkg::LT_LSB +: TOTAL_W]
         && m_tdata[wsb_pkg::RT_LSB +: TOTAL_W] >= last_data_reg[wsb_pkg::RT_LSB +: TOTAL_W])
        else $error("distance total decreased");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind wheel_speed_balancer_core wsb_checker u_wsb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the wheel speed balancer core: random stream traffic and a predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int CNT_W      = wsb_pkg::CNT_W;
    localparam int SPEED_W    = wsb_pkg::SPEED_W;
    localparam int AXIS_W     = wsb_pkg::AXIS_W;
    localparam int MPC_W      = wsb_pkg::MPC_W;
    localparam int TOTAL_W    = wsb_pkg::TOTAL_W;
    localparam int CFG_ADDR_W = wsb_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = wsb_pkg::CFG_DATA_W;
    localparam int S_TDATA_W  = wsb_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = wsb_pkg::M_TDATA_W;
    localparam int LC_LSB     = wsb_pkg::LC_LSB;
    localparam int RC_LSB     = wsb_pkg::RC_LSB;
    localparam int LD_LSB     = wsb_pkg::LD_LSB;
    localparam int RD_LSB     = wsb_pkg::RD_LSB;
    localparam int LT_LSB     = wsb_pkg::LT_LSB;
    localparam int RT_LSB     = wsb_pkg::RT_LSB;

    localparam int FRAC = wsb_pkg::DEF_FRAC_BITS;
    localparam longint DIST_TOP = (longint'(1) << wsb_pkg::DIST_W) - 1;
    localparam int BIAS_HI = (1 << (wsb_pkg::BIAS_W - 1)) - 1;
    localparam int BIAS_LO = -(1 << (wsb_pkg::BIAS_W - 1));
    localparam int SPEED_TOP = (1 << SPEED_W) - 1;
    localparam int RX_HOLD_CYCLES = 300;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] left_count;
        logic [CNT_W-1:0] right_count;
        logic             count_error;
    } tick_t;

    typedef struct packed {
        logic [SPEED_W-1:0] left_drive;
        logic [SPEED_W-1:0] right_drive;
        logic [TOTAL_W-1:0] left_total;
        logic [TOTAL_W-1:0] right_total;
        logic               skipped;
    } drive_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    wheel_speed_balancer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predicted configuration and balancer state.
    int     est_max_speed = wsb_pkg::RST_MAX_SPEED;
    longint est_wheel_axis = wsb_pkg::RST_WHEEL_AXIS;
    longint est_mm_per_count = wsb_pkg::RST_MM_PER_CNT;
    int     est_left_speed = wsb_pkg::RST_WHEEL_SPEED;
    int     est_right_speed = wsb_pkg::RST_WHEEL_SPEED;
    longint est_left_dist = 0;
    longint est_right_dist = 0;
    int     est_bias = 0;

    tick_t         pending_ticks[$];
    drive_result_t expected_drives[$];

    bit tick_xfer = 1'b0;
    bit idle_on = 1'b1;
    int send_gap = 0;
    int rx_stall = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int mismatch_count = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("wheel_speed_balancer_core test failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Whole-mm bias plus a fixed-point delta, truncated toward zero and saturated.
    function automatic int bias_shift(int b, longint d);
        longint t;
        t = (longint'(b) * (longint'(1) << FRAC) + d) / (longint'(1) << FRAC);
        if (t > BIAS_HI) return BIAS_HI;
        if (t < BIAS_LO) return BIAS_LO;
        return int'(t);
    endfunction

    function automatic longint dist_sum(longint total, longint d);
        longint s;
        s = total + d;
        return (s > DIST_TOP) ? DIST_TOP : s;
    endfunction

    function automatic int speed_sat(int s);
        if (s < 0) return 0;
        if (s > SPEED_TOP) return SPEED_TOP;
        return s;
    endfunction

    task automatic predict_tick(input logic [CNT_W-1:0] lc, input logic [CNT_W-1:0] rc,
                                input logic err);
        longint dl, dr, delta, limit, drift;
        int ls, rs, ms;
        drive_result_t r;
        if (!err) begin
            dl = longint'(lc) * est_mm_per_count;
            dr = longint'(rc) * est_mm_per_count;
            delta = dr - dl;
            ls = est_left_speed;
            rs = est_right_speed;
            ms = est_max_speed;
            limit = est_wheel_axis << (FRAC - 2);

            est_bias = bias_shift(est_bias / 2, -delta);
            if (est_bias < 0) begin
                if (wsb_pkg::NEAR_MAX_NUM * ls < wsb_pkg::NEAR_MAX_DEN * ms) ls += 1;
                else rs -= 2;
            end else if (est_bias > 0) begin
                if (wsb_pkg::NEAR_MAX_NUM * rs < wsb_pkg::NEAR_MAX_DEN * ms) rs += 1;
                else ls -= 2;
                est_bias = bias_shift(est_bias, delta);
            end

            if (ls < ms) ls += 1;
            if (rs < ms) rs += 1;

            est_left_dist = dist_sum(est_left_dist, dl);
            est_right_dist = dist_sum(est_right_dist, dr);
            drift = est_right_dist - est_left_dist;
            if (drift > limit) begin
                if (ls < ms) ls += 1;
                else rs -= 1;
            end
            if (-drift > limit) begin
                if (rs < ms) rs += 1;
                else ls -= 1;
            end

            est_left_speed = speed_sat(ls);
            est_right_speed = speed_sat(rs);
        end
        r.left_drive = est_left_speed[SPEED_W-1:0];
        r.right_drive = est_right_speed[SPEED_W-1:0];
        // A 48-bit total shifted down by the fraction always fits the 32-bit field.
        r.left_total = est_left_dist[FRAC +: TOTAL_W];
        r.right_total = est_right_dist[FRAC +: TOTAL_W];
        r.skipped = err;
        expected_drives.push_back(r);
    endtask

    task automatic report_mismatch(input string why, input drive_result_t want,
                                   input drive_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected ld=%0d rd=%0d lt=%0d rt=%0d skip=%0b,",
                      " got ld=%0d rd=%0d lt=%0d rt=%0d skip=%0b"},
                     $realtime, why, want.left_drive, want.right_drive, want.left_total,
                     want.right_total, want.skipped, got.left_drive, got.right_drive,
                     got.left_total, got.right_total, got.skipped);
    endtask

    // Input side: every transfer advances the predictor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_xfer <= 1'b0;
        end else begin
            tick_xfer <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[LC_LSB +: CNT_W], s_tdata[RC_LSB +: CNT_W], s_tuser);
        end
    end

    // Result side: compare each transfer with the oldest prediction.
    always @(posedge aclk) begin : result_check
        drive_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.left_drive = m_tdata[LD_LSB +: SPEED_W];
            got.right_drive = m_tdata[RD_LSB +: SPEED_W];
            got.left_total = m_tdata[LT_LSB +: TOTAL_W];
            got.right_total = m_tdata[RT_LSB +: TOTAL_W];
            got.skipped = m_tuser;
            if (expected_drives.size() == 0) begin
                report_mismatch("result with none expected", '0, got);
            end else begin
                want = expected_drives.pop_front();
                if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                    got.left_total !== want.left_total || got.right_total !== want.right_total ||
                    got.skipped !== want.skipped)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(negedge aclk) begin : tick_driver
        tick_t nt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tick_xfer) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (pending_ticks.size() != 0) begin
                nt = pending_ticks.pop_front();
                s_tdata <= {nt.right_count, nt.left_count};
                s_tuser <= nt.count_error;
                s_tvalid <= 1'b1;
                send_gap = idle_on ? gap_len() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            // Long hold-off so that the pipeline fills and back-pressures the input.
            hold_seen = hold_reqs;
            rx_stall = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rx_stall = gap_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_tick(input int lc, input int rc, input bit err);
        tick_t t;
        t.left_count = lc[CNT_W-1:0];
        t.right_count = rc[CNT_W-1:0];
        t.count_error = err;
        pending_ticks.push_back(t);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        case (idx)
            wsb_pkg::CFG_MAX_SPEED:    est_max_speed = data[SPEED_W-1:0];
            wsb_pkg::CFG_WHEEL_AXIS:   est_wheel_axis = data[AXIS_W-1:0];
            wsb_pkg::CFG_MM_PER_COUNT: est_mm_per_count = data[MPC_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // With junk set, the unused upper data bits carry noise that the block must drop.
    task automatic apply_settings(input int ms, input int axis, input int mpc, input bit junk);
        logic [CFG_DATA_W-1:0] hi;
        hi = junk ? CFG_DATA_W'($urandom) : '0;
        write_reg(wsb_pkg::CFG_MAX_SPEED, {hi[CFG_DATA_W-1:SPEED_W], ms[SPEED_W-1:0]});
        write_reg(wsb_pkg::CFG_WHEEL_AXIS, {hi[CFG_DATA_W-1:AXIS_W], axis[AXIS_W-1:0]});
        write_reg(wsb_pkg::CFG_MM_PER_COUNT, mpc[MPC_W-1:0]);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_tvalid) @(negedge aclk);
        while (expected_drives.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Mostly near-balanced counts steered back toward zero drift, so that the bias and
    // the drift correction keep switching sign; the rest is full-range noise.
    task automatic queue_random_ticks(input int n);
        int r, base, diff;
        bit lean_right;
        lean_right = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (i % 16 == 0) begin
                while (pending_ticks.size() > 4) @(negedge aclk);
                lean_right = (est_right_dist < est_left_dist) ^ ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r >= 90) begin
                push_tick($urandom, $urandom, $urandom_range(0, 1));
            end else begin
                base = $urandom_range(0, 400);
                diff = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 40);
                if (lean_right) push_tick(base, base + diff, r < 8);
                else push_tick(base + diff, base, r < 8);
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // Directed ticks under the reset configuration.
        push_tick(0, 0, 0);
        push_tick(0, 0, 1);
        push_tick(16'hFFFF, 0, 0);
        push_tick(0, 16'hFFFF, 0);
        push_tick(16'hFFFF, 16'hFFFF, 0);
        push_tick(16'hFFFF, 16'hFFFF, 1);
        push_tick(1, 0, 0);
        push_tick(0, 1, 0);
        push_tick(5, 5, 0);
        push_tick(1000, 900, 0);
        push_tick(900, 1000, 0);
        push_tick(123, 4567, 1);
        push_tick(16'hAAAA, 16'h5555, 0);
        push_tick(16'h5555, 16'hAAAA, 0);
        push_tick(0, 0, 0);
        push_tick(10, 10, 0);
        push_tick(300, 0, 0);
        push_tick(0, 300, 0);
        push_tick(16'h8000, 16'h7FFF, 0);
        push_tick(16'h7FFF, 16'h8000, 0);
        queue_random_ticks(200);
        wait_drained();

        apply_settings(120, 1023, 262143, 1'b0);
        queue_random_ticks(220);
        wait_drained();

        apply_settings(1, 1, 1, 1'b0);
        queue_random_ticks(200);
        wait_drained();

        // Zero registers take no special path.
        apply_settings(0, 0, 0, 1'b0);
        queue_random_ticks(60);
        wait_drained();

        apply_settings(127, 4, 65536, 1'b1);
        queue_random_ticks(220);
        wait_drained();

        apply_settings($urandom_range(1, 120), $urandom_range(1, 1023),
                       $urandom_range(1, 262143), 1'b1);
        queue_random_ticks(220);
        wait_drained();

        // Receiver holds off while the sender keeps offering back to back.
        apply_settings(30, 600, 20000, 1'b0);
        idle_on = 1'b0;
        hold_reqs++;
        queue_random_ticks(220);
        wait_drained();
        idle_on = 1'b1;

        apply_settings($urandom_range(1, 120), $urandom_range(1, 1023),
                       $urandom_range(1, 262143), 1'b0);
        queue_random_ticks(220);
        wait_drained();

        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        apply_settings(wsb_pkg::RST_MAX_SPEED, wsb_pkg::RST_WHEEL_AXIS,
                       wsb_pkg::RST_MM_PER_CNT, 1'b0);
        queue_random_ticks(220);
        wait_drained();

        // Large counts at the largest scale, back to back, so the totals grow fast.
        apply_settings(120, 1023, 262143, 1'b0);
        idle_on = 1'b0;
        for (int i = 0; i < 260; i++) begin
            if (i % 16 == 0)
                while (pending_ticks.size() > 4) @(negedge aclk);
            push_tick($urandom_range(64000, 65535), $urandom_range(65000, 65535),
                      $urandom_range(0, 19) == 0);
        end
        idle_on = 1'b1;
        queue_random_ticks(40);
        wait_drained();
        repeat (20) @(negedge aclk);

        if (mismatch_count == 0 && expected_drives.size() == 0) begin
            $display("wheel_speed_balancer_core test passed");
        end else begin
            $display("wheel_speed_balancer_core test failed");
        end
        $finish;
    end

endmodule
